FILE: rtl/multichannel_moving_median_assert.svh
// assertion macros shared by the moving median rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef MULTICHANNEL_MOVING_MEDIAN_ASSERT_SVH
`define MULTICHANNEL_MOVING_MEDIAN_ASSERT_SVH

// property checked at every clock edge outside reset
`define MMM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mmm_pkg.sv
// constants and types of the multichannel moving median
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmm_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int CHANNELS   = 8;
	localparam int DATA_W     = 32;
	localparam int CH_W       = 3;
	localparam int LEN_W      = 5;
	localparam int ROW_W      = $clog2(MAX_WINDOW);
	localparam int ADDR_W     = ROW_W + CH_W;
	localparam int STORE_DEPTH = MAX_WINDOW * CHANNELS;
	localparam int PTR_W      = ROW_W + 2;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic signed [PTR_W-1:0] ptr_t;

	// one write into the selection buffer
	typedef struct packed {
		logic    we;
		row_t    idx;
		sample_t data;
	} mmm_ld_t;

	typedef struct packed {
		logic start;
		row_t hi;
		row_t k;
	} mmm_sel_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} mmm_sel_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/mmm_in_if.sv
// input channel of the moving median: one sample beat
// depends on mmm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mmm_in_if;
	logic                        valid;
	logic                        ready;
	logic [mmm_pkg::CH_W-1:0]    channel;
	logic signed [mmm_pkg::DATA_W-1:0] sample_value;
	logic                        last_of_observation;

	modport source (output valid, channel, sample_value, last_of_observation, input ready);
	modport sink (input valid, channel, sample_value, last_of_observation, output ready);
endinterface

`default_nettype wire

FILE: rtl/mmm_out_if.sv
// output channel of the moving median: one median beat
// depends on mmm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mmm_out_if;
	logic                        valid;
	logic                        ready;
	logic [mmm_pkg::CH_W-1:0]    out_channel;
	logic signed [mmm_pkg::DATA_W-1:0] median_value;
	logic                        out_last;

	modport source (output valid, out_channel, median_value, out_last, input ready);
	modport sink (input valid, out_channel, median_value, out_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/multichannel_moving_median.sv
// Multichannel moving median with per-channel ring windows.
// Channels: samples (sink) takes one channel sample per beat, medians (source)
// returns one beat per sample with the channel, the lower median of that
// channel's window and the last-of-observation flag. cfg_we/cfg_wdata set
// window_length (0 acts as 1, above 16 acts as 16); write it only while idle.
// Each beat is written to the sample store at the current row, then the
// channel's n filled rows are copied one per cycle into the selection buffer
// and a partition selection runs on one shared comparator.
// From the input beat, the sample is stored, the channel's rows are copied,
// the selection is started and scans, swaps and partitions until it finishes,
// and the median is then registered. The next sample can be taken from the
// cycle after its median is registered, so samples never overlap in work;
// samples.ready is low while a sample is in work.
// The row advances after a beat with last_of_observation set.
// Reset: write row and fill count clear, window_length returns to 16; the
// sample store is not cleared and every channel must be written each
// observation. A stalled receiver holds the median in the output register;
// the next sample is still taken and waits at the end of its selection.
// depends on mmm_pkg, mmm_in_if, mmm_out_if, mmm_select, assertion header
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_moving_median_assert.svh"

module multichannel_moving_median (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	mmm_in_if.sink                          samples,
	mmm_out_if.source                       medians,
	input  wire logic                       cfg_we,
	input  wire logic [mmm_pkg::LEN_W-1:0]  cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STORE,
		S_LOAD,
		S_DRAIN,
		S_SEL,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [mmm_pkg::LEN_W-1:0] window_length_q;
	mmm_pkg::row_t             write_row_q;
	logic [mmm_pkg::LEN_W-1:0] filled_rows_q;

	logic [mmm_pkg::CH_W-1:0] ch_q;
	mmm_pkg::sample_t         sample_q;
	logic                     last_q;
	mmm_pkg::row_t            wrow_q;
	mmm_pkg::row_t            hi_q;
	mmm_pkg::row_t            rd_row_q;
	logic                     ld_v_s1;
	mmm_pkg::row_t            ld_idx_s1;

	mmm_pkg::sample_t store_mem [mmm_pkg::STORE_DEPTH];
	mmm_pkg::sample_t store_rd_q;

	logic                     out_valid_q;
	logic [mmm_pkg::CH_W-1:0] out_ch_q;
	mmm_pkg::sample_t         out_med_q;
	logic                     out_last_q;

	logic [mmm_pkg::LEN_W-1:0] len;
	mmm_pkg::row_t             cur_row;
	logic [mmm_pkg::LEN_W-1:0] cnt_raw, cnt;
	logic [mmm_pkg::LEN_W-1:0] next_row;
	logic                      accept;

	mmm_pkg::mmm_ld_t      ld;
	mmm_pkg::mmm_sel_req_t req;
	mmm_pkg::mmm_sel_rsp_t rsp;
	mmm_pkg::sample_t      sel_result;

	always_comb begin
		if (window_length_q == '0) begin
			len = mmm_pkg::LEN_W'(1);
		end else if (window_length_q > mmm_pkg::LEN_W'(mmm_pkg::MAX_WINDOW)) begin
			len = mmm_pkg::LEN_W'(mmm_pkg::MAX_WINDOW);
		end else begin
			len = window_length_q;
		end
	end

	// window may have shrunk since the row was last advanced
	assign cur_row  = ({1'b0, write_row_q} >= len) ? '0 : write_row_q;
	assign cnt_raw  = filled_rows_q + mmm_pkg::LEN_W'(1);
	assign cnt      = (cnt_raw > len) ? len : cnt_raw;
	assign next_row = {1'b0, cur_row} + mmm_pkg::LEN_W'(1);

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= mmm_pkg::LEN_W'(mmm_pkg::MAX_WINDOW);
		end else if (cfg_we) begin
			window_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STORE) begin
			store_mem[{wrow_q, ch_q}] <= sample_q;
		end
		store_rd_q <= store_mem[{rd_row_q, ch_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			write_row_q   <= '0;
			filled_rows_q <= '0;
			ld_v_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			ld_v_s1 <= 1'b0;
			// the emit state reloads the output register itself
			if (medians.valid && medians.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q     <= samples.channel;
						sample_q <= samples.sample_value;
						last_q   <= samples.last_of_observation;
						wrow_q   <= cur_row;
						hi_q     <= mmm_pkg::ROW_W'(cnt - mmm_pkg::LEN_W'(1));
						if (samples.last_of_observation) begin
							write_row_q   <= (next_row >= len) ? '0
								: next_row[mmm_pkg::ROW_W-1:0];
							filled_rows_q <= (filled_rows_q < len) ? cnt_raw : len;
						end else begin
							write_row_q <= cur_row;
						end
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					rd_row_q <= '0;
					state_q  <= S_LOAD;
				end
				S_LOAD: begin
					// read of rd_row_q issued now, lands in the buffer next cycle
					ld_v_s1   <= 1'b1;
					ld_idx_s1 <= rd_row_q;
					if (rd_row_q == hi_q) begin
						state_q <= S_DRAIN;
					end else begin
						rd_row_q <= rd_row_q + mmm_pkg::ROW_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || medians.ready) begin
						out_valid_q <= 1'b1;
						out_ch_q    <= ch_q;
						out_med_q   <= sel_result;
						out_last_q  <= last_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ld.we    = ld_v_s1;
	assign ld.idx   = ld_idx_s1;
	assign ld.data  = store_rd_q;
	assign req.start = (state_q == S_DRAIN);
	assign req.hi    = hi_q;
	assign req.k     = hi_q >> 1;

	mmm_select u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.req    (req),
		.rsp    (rsp),
		.result (sel_result)
	);

	assign medians.valid        = out_valid_q;
	assign medians.out_channel  = out_ch_q;
	assign medians.median_value = out_med_q;
	assign medians.out_last     = out_last_q;

	`MMM_ASSERT_NEXT(a_busy_after_beat, accept, !samples.ready, "input taken while a sample is in work")
	`MMM_ASSERT(a_fill_bound, filled_rows_q <= mmm_pkg::LEN_W'(mmm_pkg::MAX_WINDOW), "fill count beyond window")
	`MMM_ASSERT(a_load_in_window, ld_v_s1 |-> (ld_idx_s1 <= hi_q && !rsp.busy), "buffer load outside window or during selection")
	`MMM_ASSERT(a_emit_from_sel, $rose(out_valid_q) |-> $past(state_q == S_EMIT), "median shown without finished selection")

endmodule

`default_nettype wire

FILE: rtl/mmm_select.sv
// partition selection unit: selection buffer memory and one shared comparator
// depends on mmm_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_moving_median_assert.svh"

module mmm_select (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mmm_pkg::mmm_ld_t      ld,
	input  wire mmm_pkg::mmm_sel_req_t req,
	output mmm_pkg::mmm_sel_rsp_t      rsp,
	output mmm_pkg::sample_t           result
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_OUTER,
		S_PIV,
		S_SCAN_I,
		S_SCAN_J,
		S_SWAP,
		S_NEXT,
		S_PART,
		S_RES
	} state_t;

	state_t state_q;

	mmm_pkg::sample_t sel_mem [mmm_pkg::MAX_WINDOW];
	mmm_pkg::sample_t rd_data_q;
	mmm_pkg::sample_t pivot_q;
	mmm_pkg::sample_t a_val_q;
	mmm_pkg::sample_t result_q;
	mmm_pkg::ptr_t    lo_q, hi_q, k_q, i_q, j_q;
	logic             done_q;

	mmm_pkg::ptr_t    i_inc, j_dec;
	mmm_pkg::sample_t cmp_a, cmp_b;
	logic             lt;
	logic             mem_we;
	mmm_pkg::row_t    mem_waddr;
	mmm_pkg::row_t    rd_addr;
	mmm_pkg::sample_t mem_wdata;

	assign i_inc = i_q + mmm_pkg::ptr_t'(1);
	assign j_dec = j_q - mmm_pkg::ptr_t'(1);

	// the one comparator, operands swapped between the two scans
	always_comb begin
		if (state_q == S_SCAN_I) begin
			cmp_a = rd_data_q;
			cmp_b = pivot_q;
		end else begin
			cmp_a = pivot_q;
			cmp_b = rd_data_q;
		end
	end
	assign lt = cmp_a < cmp_b;

	always_comb begin
		case (state_q)
			S_PIV:    rd_addr = i_q[mmm_pkg::ROW_W-1:0];
			S_SCAN_I: rd_addr = lt ? i_inc[mmm_pkg::ROW_W-1:0] : j_q[mmm_pkg::ROW_W-1:0];
			S_SCAN_J: rd_addr = j_dec[mmm_pkg::ROW_W-1:0];
			S_NEXT:   rd_addr = i_q[mmm_pkg::ROW_W-1:0];
			default:  rd_addr = k_q[mmm_pkg::ROW_W-1:0];
		endcase
	end

	// swap takes two writes: left slot in the scan cycle, right slot after
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ld.idx;
		mem_wdata = ld.data;
		if (ld.we) begin
			mem_we = 1'b1;
		end else if (state_q == S_SCAN_J && !lt && i_q <= j_q) begin
			mem_we    = 1'b1;
			mem_waddr = i_q[mmm_pkg::ROW_W-1:0];
			mem_wdata = rd_data_q;
		end else if (state_q == S_SWAP) begin
			mem_we    = 1'b1;
			mem_waddr = j_q[mmm_pkg::ROW_W-1:0];
			mem_wdata = a_val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sel_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= sel_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						lo_q    <= '0;
						hi_q    <= mmm_pkg::ptr_t'(req.hi);
						k_q     <= mmm_pkg::ptr_t'(req.k);
						state_q <= S_OUTER;
					end
				end
				S_OUTER: begin
					if (lo_q < hi_q) begin
						i_q     <= lo_q;
						j_q     <= hi_q;
						state_q <= S_PIV;
					end else begin
						state_q <= S_RES;
					end
				end
				S_PIV: begin
					pivot_q <= rd_data_q;
					state_q <= S_SCAN_I;
				end
				S_SCAN_I: begin
					if (lt) begin
						i_q <= i_inc;
					end else begin
						a_val_q <= rd_data_q;
						state_q <= S_SCAN_J;
					end
				end
				S_SCAN_J: begin
					if (lt) begin
						j_q <= j_dec;
					end else if (i_q <= j_q) begin
						state_q <= S_SWAP;
					end else begin
						state_q <= S_PART;
					end
				end
				S_SWAP: begin
					i_q <= i_inc;
					j_q <= j_dec;
					state_q <= (i_inc <= j_dec) ? S_NEXT : S_PART;
				end
				S_NEXT: begin
					state_q <= S_SCAN_I;
				end
				S_PART: begin
					if (j_q < k_q) begin
						lo_q <= i_q;
					end
					if (k_q < i_q) begin
						hi_q <= j_q;
					end
					state_q <= S_OUTER;
				end
				S_RES: begin
					result_q <= rd_data_q;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = (state_q != S_IDLE);
	assign result   = result_q;

	`MMM_ASSERT(a_i_in_range, (state_q == S_SCAN_I) |-> (i_q >= 0 && i_q < mmm_pkg::MAX_WINDOW), "left scan index out of buffer")
	`MMM_ASSERT(a_j_in_range, (state_q == S_SCAN_J) |-> (j_q >= 0 && j_q < mmm_pkg::MAX_WINDOW), "right scan index out of buffer")
	`MMM_ASSERT_NEXT(a_done_pulse, done_q, !done_q && state_q == S_IDLE, "done not a single pulse")

endmodule

`default_nettype wire

FILE: test/tb_multichannel_moving_median.sv
`timescale 1ns / 1ps

// self-checking testbench for multichannel_moving_median: sample beats per channel
// against an in-bench lower-median predictor over per-channel ring windows
// depends on mmm_pkg, mmm_in_if, mmm_out_if and the multichannel_moving_median top

module tb_multichannel_moving_median;
	import mmm_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int PHASES       = 13;
	localparam int PHASE_OBS    = 10;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_EVERY   = 500;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [CH_W-1:0] ch;
		sample_t         value;
		logic            last;
	} channel_beat_t;

	// shapes of one observation on the sample channel
	typedef enum int {
		OBS_CLEAN,
		OBS_DROP,
		OBS_REPEAT,
		OBS_NO_LAST,
		OBS_SPLIT
	} obs_shape_e;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	mmm_in_if  sample_bus ();
	mmm_out_if median_bus ();

	multichannel_moving_median u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_bus),
		.medians   (median_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	channel_beat_t samples_to_send [$];
	channel_beat_t medians_due [$];
	channel_beat_t drive_beat;
	channel_beat_t want_beat;

	int unsigned send_gap_pct = 7;
	int unsigned recv_stall_pct = 7;
	int          fail_count = 0;
	int          medians_seen;
	int          hold_left;

	// predictor copy of the window state
	sample_t          win_store [MAX_WINDOW][CHANNELS];
	int               row_ptr;
	int               rows_done;
	logic [LEN_W-1:0] win_len_reg;

	function automatic int active_len();
		if (win_len_reg == 0) return 1;
		if (win_len_reg > MAX_WINDOW) return MAX_WINDOW;
		return int'(win_len_reg);
	endfunction

	// stores the sample and returns the lower median of the channel's window
	function automatic sample_t take_window_sample(input logic [CH_W-1:0] ch,
			input sample_t v, input logic last);
		sample_t ordered [MAX_WINDOW];
		sample_t t;
		int      len;
		int      cnt;
		int      i;
		int      j;
		len = active_len();
		if (row_ptr >= len) row_ptr = 0;
		cnt = (rows_done + 1 > len) ? len : rows_done + 1;
		win_store[row_ptr][ch] = v;
		for (i = 0; i < cnt; i++) ordered[i] = win_store[i][ch];
		for (i = 1; i < cnt; i++) begin
			t = ordered[i];
			j = i - 1;
			while (j >= 0 && ordered[j] > t) begin
				ordered[j + 1] = ordered[j];
				j--;
			end
			ordered[j + 1] = t;
		end
		if (last) begin
			row_ptr++;
			if (row_ptr >= len) row_ptr = 0;
			if (rows_done < len) rows_done++;
			if (rows_done > len) rows_done = len;
		end
		return ordered[(cnt - 1) / 2];
	endfunction

	function automatic sample_t extreme_value(input int k);
		case (k)
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sh0000_0000;
			3: return 32'shffff_ffff;
			4: return 32'sh0000_0001;
			5: return 32'sh0001_0000;
			6: return 32'shffff_0000;
			default: return 32'sh5555_5555;
		endcase
	endfunction

	// mix of full range, tight clusters for ties, extremes and small Q16.16 values
	function automatic sample_t pick_value();
		case ($urandom_range(3))
			0: return sample_t'($urandom);
			1: return sample_t'(int'($urandom_range(8)) - 4);
			2: return extreme_value($urandom_range(7));
			default: return sample_t'(int'($urandom_range(131072)) - 65536);
		endcase
	endfunction

	task automatic queue_sample(input logic [CH_W-1:0] ch, input sample_t v,
			input logic last);
		channel_beat_t b;
		b.ch = ch;
		b.value = v;
		b.last = last;
		samples_to_send.push_back(b);
		b.value = take_window_sample(ch, v, last);
		medians_due.push_back(b);
	endtask

	// broken shapes only once every row of every channel has been written
	task automatic queue_observations(input int n, input bit allow_broken);
		logic [CH_W-1:0] order [$];
		logic [CH_W-1:0] tmp;
		obs_shape_e      shape;
		int              o;
		int              i;
		int              j;
		int              split_at;
		for (o = 0; o < n; o++) begin
			order.delete();
			for (i = 0; i < CHANNELS; i++) order.push_back(CH_W'(i));
			for (i = CHANNELS - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			shape = OBS_CLEAN;
			if (allow_broken && $urandom_range(99) < 25)
				shape = obs_shape_e'($urandom_range(OBS_DROP, OBS_SPLIT));
			if (shape == OBS_DROP) begin
				order.delete($urandom_range(CHANNELS - 1));
			end else if (shape == OBS_REPEAT) begin
				tmp = order[$urandom_range(CHANNELS - 1)];
				order.insert($urandom_range(CHANNELS), tmp);
			end
			split_at = (shape == OBS_SPLIT) ? $urandom_range(order.size() - 2) : -1;
			for (i = 0; i < order.size(); i++)
				queue_sample(order[i], pick_value(), (i == split_at) ||
					(i == order.size() - 1 && shape != OBS_NO_LAST));
		end
	endtask

	task automatic wait_drained();
		while (samples_to_send.size() != 0 || sample_bus.valid || medians_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window_length(input logic [LEN_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_len_reg = v;
	endtask

	// sample driver: holds a beat until taken, then maybe idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
		end else if (!sample_bus.valid || sample_bus.ready) begin
			if (samples_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				drive_beat = samples_to_send.pop_front();
				sample_bus.valid <= 1'b1;
				sample_bus.channel <= drive_beat.ch;
				sample_bus.sample_value <= drive_beat.value;
				sample_bus.last_of_observation <= drive_beat.last;
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	// median monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_bus.ready <= 1'b0;
			medians_seen <= 0;
			hold_left <= 0;
		end else begin
			if (median_bus.valid && median_bus.ready) begin
				if (medians_due.size() == 0) begin
					fail_count++;
					$display("%0t: median beat with nothing expected: ch %0d median %0d last %0b",
						$time, median_bus.out_channel, median_bus.median_value,
						median_bus.out_last);
				end else begin
					want_beat = medians_due.pop_front();
					if (median_bus.out_channel !== want_beat.ch ||
							median_bus.median_value !== want_beat.value ||
							median_bus.out_last !== want_beat.last) begin
						fail_count++;
						$display("%0t: median mismatch: expected ch %0d median %0d last %0b, got ch %0d median %0d last %0b",
							$time, want_beat.ch, want_beat.value, want_beat.last,
							median_bus.out_channel, median_bus.median_value,
							median_bus.out_last);
					end
				end
				medians_seen <= medians_seen + 1;
			end
			// long hold-off now and then so the block backs up into its input
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				median_bus.ready <= 1'b0;
			end else if (median_bus.valid && median_bus.ready &&
					medians_seen % HOLD_EVERY == HOLD_EVERY / 2) begin
				hold_left <= HOLD_CYCLES;
				median_bus.ready <= 1'b0;
			end else begin
				median_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int               o;
		int               i;
		int               p;
		logic [CH_W-1:0]  c;
		logic [LEN_W-1:0] len_sel;
		sample_bus.valid = 1'b0;
		sample_bus.channel = '0;
		sample_bus.sample_value = '0;
		sample_bus.last_of_observation = 1'b0;
		median_bus.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		win_len_reg = LEN_W'(MAX_WINDOW);
		row_ptr = 0;
		rows_done = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// window filling from one to three rows with extreme values,
		// second observation in reverse channel order
		for (o = 0; o < 3; o++) begin
			for (i = 0; i < CHANNELS; i++) begin
				c = (o == 1) ? CH_W'(CHANNELS - 1 - i) : CH_W'(i);
				queue_sample(c, extreme_value((int'(c) + 3 * o) % 8), i == CHANNELS - 1);
			end
		end
		// clean observations until every row of the full window has wrapped
		queue_observations(MAX_WINDOW + 1, 1'b0);

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: len_sel = 1;
				1: len_sel = 0;
				2: len_sel = 31;
				3: len_sel = 5;
				4: len_sel = 16;
				5: len_sel = 2;
				6: len_sel = 17;
				PHASES - 1: len_sel = 16;
				default: len_sel = LEN_W'($urandom_range(1, MAX_WINDOW));
			endcase
			write_window_length(len_sel);
			send_gap_pct = (p == 4) ? 0 : 7;
			recv_stall_pct = (p == 4) ? 0 : 7;
			queue_observations(PHASE_OBS, 1'b1);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
